>>> hw/rtl/skdt_pkg.sv
// shared types and codes for the sorted key dispatch table
`timescale 1ns / 1ps

package skdt_pkg;

    localparam int KEY_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_LOOKUP = 2'd1;
    localparam kind_t KIND_CLEAR  = 2'd2;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_DUP  = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_MISS = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_PROBE  = 6'b000100,
        S_CHECK  = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_MOVE   = 6'b100000
    } state_t;

endpackage

>>> hw/rtl/skdt_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module skdt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/sorted_key_dispatch_table.sv
// sorted key dispatch table: binary search, insert with shift, lookup and clear
`timescale 1ns / 1ps

// Each command is one transfer: start is taken while busy is low, and one
// result follows with a one-cycle done strobe that the receiver must take.
// Clear and the unused kind finish without leaving idle and keep busy low.
// Insert and lookup run a binary search through the single read port of the
// entry ram: each halving step sets the address, then compares the registered
// read data; an equality probe of the lower bound, when it lies inside the
// table, follows, then the report. A successful insert then moves the later
// entries up one at a time through the same port, a read then a write per
// moved entry, and then stores the new entry. A full table of TABLE_DEPTH
// entries reports table full without a shift. A new start can be taken in the
// cycle that done is shown.
module sorted_key_dispatch_table
    import skdt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 16,
    parameter int HANDLER_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [KIND_W-1:0]                 kind,
    input  logic [KEY_W-1:0]                  key,
    input  logic [HANDLER_BITS-1:0]           handler_id,
    output logic                              done,
    output logic [STAT_W-1:0]                 status,
    output logic [HANDLER_BITS-1:0]           found_handler,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  slot
);

    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = KEY_W + HANDLER_BITS;
    localparam logic [SW-1:0] ONE  = SW'(1);
    localparam logic [SW-1:0] FULL = SW'(TABLE_DEPTH);

    state_t state_reg, state_next;
    logic [SW-1:0] lo_reg, lo_next;
    logic [SW-1:0] hi_reg, hi_next;
    logic [SW-1:0] mid_reg, mid_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [SW-1:0] count_reg, count_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    logic [HANDLER_BITS-1:0] found_reg, found_next;
    logic [SW-1:0] slot_reg, slot_next;

    kind_t                   kind_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [HANDLER_BITS-1:0] hid_reg;

    logic          accept;
    logic [SW-1:0] mid_w;
    logic [SW-1:0] idx_dec;
    logic          finish;
    logic          hit;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic [KEY_W-1:0]        rd_key;
    logic [HANDLER_BITS-1:0] rd_hdl;

    skdt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[EW-1:HANDLER_BITS];
    assign rd_hdl  = ram_rdata[HANDLER_BITS-1:0];
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign mid_w   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec = idx_reg - ONE;

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        slot_next   = slot_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        finish      = 1'b0;
        hit         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lo_next = '0;
                    hi_next = count_reg;
                    if (kind inside {KIND_INSERT, KIND_LOOKUP})
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        found_next  = '0;
                        slot_next   = '0;
                        if (kind == KIND_CLEAR)
                        begin
                            count_next = '0;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_w;
                    ram_raddr  = mid_w[AW-1:0];
                    state_next = S_PROBE;
                end
                else if (lo_reg < count_reg)
                begin
                    // probe the lower bound for an equal key
                    ram_raddr  = lo_reg[AW-1:0];
                    state_next = S_CHECK;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            S_PROBE:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid_reg + ONE;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                finish = 1'b1;
                hit    = (rd_key == key_reg);
            end
            S_SHIFT:
            begin
                if (idx_reg > slot_reg)
                begin
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_MOVE;
                end
                else
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = slot_reg[AW-1:0];
                    ram_wdata   = {key_reg, hid_reg};
                    count_next  = count_reg + ONE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            S_MOVE:
            begin
                // entry read from idx-1 lands one slot up
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = S_SHIFT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            slot_next  = lo_reg;
            found_next = '0;
            if (kind_reg == KIND_LOOKUP)
            begin
                done_next   = 1'b1;
                status_next = hit ? ST_OK : ST_MISS;
                found_next  = hit ? rd_hdl : '0;
                state_next  = S_IDLE;
            end
            else if (hit)
            begin
                done_next   = 1'b1;
                status_next = ST_DUP;
                state_next  = S_IDLE;
            end
            else if (count_reg == FULL)
            begin
                done_next   = 1'b1;
                status_next = ST_FULL;
                state_next  = S_IDLE;
            end
            else
            begin
                idx_next   = count_reg;
                state_next = S_SHIFT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        slot_reg   <= slot_next;
        if (accept)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            hid_reg  <= handler_id;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign found_handler = found_reg;
    assign slot          = slot_reg;

endmodule
